[rtl/core/window_steady_state_detector_defines.svh]
// assertion macros used by the checker file of the steady-state detector
`ifndef WINDOW_STEADY_STATE_DETECTOR_DEFINES_SVH
`define WINDOW_STEADY_STATE_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define WSSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define WSSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wssd_pkg.sv]
// shared constants and types of the steady-state detector
package wssd_pkg;

  // default sizes
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // register field widths and reset values
  localparam int WLEN_W = 7;
  localparam int THR_W  = 16;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd3277;

  // bus widths
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LEN = 1'b0;
  localparam logic REG_OSC_THR    = 1'b1;

  // step commands from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic clear;
    logic acc;
    logic mul_nmax;
    logic mul_p2p;
    logic mul_lim;
    logic cmp_dev;
    logic cmp_p2p;
  } wssd_ctl_t;

endpackage

[rtl/core/window_steady_state_detector.sv]
// sliding-window peak-to-peak steady-state detector, top level
//
//  channel | direction | handshake                 | payload
//  in      | to block  | in_valid_i / in_stall_o   | sample_i, restart_i
//  out     | from block| out_valid_o / out_stall_i | in_steady_state_o, window_full_o
//  cfg     | to block  | APB psel/penable/pready   | window_len @0x0, osc_threshold @0x4
//
// A restart or a beat that leaves the window short gives its result in the next cycle.
// A beat that fills the window walks it through the ring memory, one entry a cycle,
// then runs five steps on the shared multiplier/comparator; the result is loaded in the
// done state once the output slot is free, and the next beat is taken only after that.
// Input is stalled while a walk runs or while a result waits on a stalled output.
// No clearing pass after reset; writing window_len empties the window.
module window_steady_state_detector #(
  parameter int MAX_WINDOW  = wssd_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wssd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input beats
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic                        restart_i,
  // result beats
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        in_steady_state_o,
  output logic                        window_full_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wssd_pkg::APB_AW-1:0] paddr,
  input  logic [wssd_pkg::APB_DW-1:0] pwdata,
  output logic [wssd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int WLEN_W = wssd_pkg::WLEN_W;
  localparam int THR_W  = wssd_pkg::THR_W;
  localparam int CMP_W  = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WALK = 8'b0000_0010,
    S_NMAX = 8'b0000_0100,
    S_P2P  = 8'b0000_1000,
    S_LIM  = 8'b0001_0000,
    S_CDEV = 8'b0010_0000,
    S_CP2P = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } wssd_state_e;

  wssd_state_e state_q, state_d;

  logic [WLEN_W-1:0] wl_q;
  logic [THR_W-1:0]  thr_q;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic              out_valid_q, out_valid_d;
  logic              steady_q, full_q;

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_q;

  logic [LEN_W-1:0]  n;
  logic [ADDR_W-1:0] wp_eff;
  logic [LEN_W-1:0]  wp_inc;
  logic [LEN_W-1:0]  fill_inc;
  logic              in_acc;
  logic              out_free;
  logic              cfg_we;
  logic              wl_clr;
  logic              mem_we;
  logic              rd_en;
  logic              res_load;
  logic              res_steady;
  logic              res_full;
  logic              judge_steady;
  wssd_pkg::wssd_ctl_t ctl;

  // effective window length: zero acts as one, clamped to the ring size
  always_comb begin
    if (wl_q == '0) begin
      n = LEN_W'(1);
    end else if (CMP_W'(wl_q) > CMP_W'(MAX_WINDOW)) begin
      n = LEN_W'(MAX_WINDOW);
    end else begin
      n = LEN_W'(wl_q);
    end
  end

  // handshakes
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite && pready;
  assign wl_clr     = cfg_we && (paddr[2] == wssd_pkg::REG_WINDOW_LEN);

  // ring pointer and fill count for the incoming sample
  assign wp_eff   = (LEN_W'(wp_q) >= n) ? '0 : wp_q;
  assign wp_inc   = LEN_W'(wp_eff) + LEN_W'(1);
  assign fill_inc = (fill_q < n) ? (fill_q + LEN_W'(1)) : fill_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    res_load   = 1'b0;
    res_steady = 1'b0;
    res_full   = 1'b0;
    ctl        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (restart_i) begin
            wp_d     = '0;
            fill_d   = '0;
            res_load = 1'b1;
          end else begin
            mem_we = 1'b1;
            wp_d   = (wp_inc >= n) ? '0 : wp_inc[ADDR_W-1:0];
            fill_d = fill_inc;
            if (fill_inc == n) begin
              state_d   = S_WALK;
              cnt_d     = '0;
              ctl.clear = 1'b1;
            end else begin
              res_load = 1'b1;
            end
          end
        end
      end
      S_WALK: begin
        rd_en    = cnt_q < n;
        rd_vld_d = rd_en;
        ctl.acc  = rd_vld_q;
        if (rd_en) cnt_d = cnt_q + LEN_W'(1);
        if (!rd_en && rd_vld_q) state_d = S_NMAX;
      end
      S_NMAX: begin
        ctl.mul_nmax = 1'b1;
        state_d      = S_P2P;
      end
      S_P2P: begin
        ctl.mul_p2p = 1'b1;
        state_d     = S_LIM;
      end
      S_LIM: begin
        ctl.mul_lim = 1'b1;
        state_d     = S_CDEV;
      end
      S_CDEV: begin
        ctl.cmp_dev = 1'b1;
        state_d     = S_CP2P;
      end
      S_CP2P: begin
        ctl.cmp_p2p = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_steady = judge_steady;
          res_full   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // a new window length empties the window
    if (wl_clr) begin
      wp_d   = '0;
      fill_d = '0;
    end
  end

  // output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      wl_q        <= wssd_pkg::WLEN_RESET;
      thr_q       <= wssd_pkg::THR_RESET;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        unique case (paddr[2])
          wssd_pkg::REG_WINDOW_LEN: begin
            wl_q <= pwdata[WLEN_W-1:0];
          end
          wssd_pkg::REG_OSC_THR: begin
            thr_q <= pwdata[THR_W-1:0];
          end
          default: begin
            thr_q <= thr_q;
          end
        endcase
      end
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[2])
      wssd_pkg::REG_WINDOW_LEN: prdata = wssd_pkg::APB_DW'(wl_q);
      wssd_pkg::REG_OSC_THR:    prdata = wssd_pkg::APB_DW'(thr_q);
      default:                  prdata = '0;
    endcase
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      steady_q <= res_steady;
      full_q   <= res_full;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign in_steady_state_o = steady_q;
  assign window_full_o     = full_q;

  // sample ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_eff] <= sample_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem[cnt_q[ADDR_W-1:0]];
  end

  // shared arithmetic unit
  wssd_judge #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W)
  ) u_judge (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .smp_i    (rd_data_q),
    .n_i      (n),
    .thr_i    (thr_q),
    .steady_o (judge_steady)
  );

endmodule

[rtl/core/wssd_judge.sv]
// shared multiply/compare unit: window statistics and the oscillation verdict
module wssd_judge #(
  parameter int SAMPLE_BITS = wssd_pkg::SAMPLE_BITS_DEF,
  parameter int LEN_W       = 7
) (
  input  logic                     clk_i,
  input  wssd_pkg::wssd_ctl_t      ctl_i,
  input  logic [SAMPLE_BITS-1:0]   smp_i,
  input  logic [LEN_W-1:0]         n_i,
  input  logic [wssd_pkg::THR_W-1:0] thr_i,
  output logic                     steady_o
);

  localparam int THR_W  = wssd_pkg::THR_W;
  localparam int SUM_W  = SAMPLE_BITS + LEN_W;
  localparam int MB_W   = (LEN_W > THR_W) ? LEN_W : THR_W;
  localparam int PROD_W = SUM_W + MB_W;
  localparam int LIM_W  = SUM_W + THR_W;

  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] lo_q;
  logic [SAMPLE_BITS-1:0] hi_q;
  logic [SUM_W-1:0]       nmax_q;
  logic [SUM_W-1:0]       dev_q;
  logic [SUM_W-1:0]       p2p_q;
  logic [LIM_W-1:0]       lim_q;
  logic                   bad_q;

  logic [SUM_W-1:0]  mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  dev_d;
  logic [SUM_W-1:0]  cmp_a;
  logic              over;

  // operand selection for the single multiplier
  always_comb begin
    if (ctl_i.mul_lim) begin
      mul_a = sum_q;
      mul_b = MB_W'(thr_i);
    end else if (ctl_i.mul_p2p) begin
      mul_a = SUM_W'(hi_q - lo_q);
      mul_b = MB_W'(n_i);
    end else begin
      mul_a = SUM_W'(hi_q);
      mul_b = MB_W'(n_i);
    end
  end

  assign prod = {{MB_W{1'b0}}, mul_a} * {{SUM_W{1'b0}}, mul_b};

  // distance of n*max from the sum
  assign dev_d = (nmax_q >= sum_q) ? (nmax_q - sum_q) : (sum_q - nmax_q);

  // shared comparator against threshold*sum
  assign cmp_a = ctl_i.cmp_dev ? dev_q : p2p_q;
  assign over  = {cmp_a, {THR_W{1'b0}}} >= lim_q;

  // accumulators and intermediate results
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      sum_q <= '0;
      lo_q  <= '1;
      hi_q  <= '0;
      bad_q <= 1'b0;
    end
    if (ctl_i.acc) begin
      sum_q <= sum_q + SUM_W'(smp_i);
      if (smp_i < lo_q) lo_q <= smp_i;
      if (smp_i > hi_q) hi_q <= smp_i;
    end
    if (ctl_i.mul_nmax) nmax_q <= prod[SUM_W-1:0];
    if (ctl_i.mul_p2p) begin
      p2p_q <= prod[SUM_W-1:0];
      dev_q <= dev_d;
    end
    if (ctl_i.mul_lim) lim_q <= prod[LIM_W-1:0];
    if ((ctl_i.cmp_dev || ctl_i.cmp_p2p) && over) bad_q <= 1'b1;
  end

  // an all-zero window is steady
  assign steady_o = (sum_q == '0) || !bad_q;

endmodule

[rtl/core/wssd_checker.sv]
// port-level checks of the steady-state detector and their binding
`include "window_steady_state_detector_defines.svh"

module wssd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic restart_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic in_steady_state_o,
  input logic window_full_o
);

  // a stalled result beat stays offered
  `WSSD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result beat dropped under stall")

  // steady is only reported on a full window
  `WSSD_ASSERT_IMPL(a_steady_full, out_valid_o && in_steady_state_o, window_full_o, "steady without full window")

  // a taken restart beat is answered with an empty, unsteady result
  `WSSD_ASSERT_NEXT(a_restart_res, in_valid_i && !in_stall_o && restart_i, out_valid_o && !window_full_o && !in_steady_state_o, "restart result wrong")

  // no new beat is taken while a result is blocked
  `WSSD_ASSERT_IMPL(a_back_press, out_valid_o && out_stall_i, in_stall_o, "input taken while output blocked")

endmodule

bind window_steady_state_detector wssd_checker u_wssd_checker (.*);

[verif/tb_window_steady_state_detector.sv]
// testbench for the window steady-state detector: predicted verdicts checked beat by beat
module tb_window_steady_state_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = wssd_pkg::SAMPLE_BITS_DEF;
  localparam int MAX_W = wssd_pkg::MAX_WINDOW_DEF;
  localparam int APB_AW = wssd_pkg::APB_AW;
  localparam int APB_DW = wssd_pkg::APB_DW;
  localparam int WLEN_W = wssd_pkg::WLEN_W;
  localparam int THR_W = wssd_pkg::THR_W;
  localparam logic [WLEN_W-1:0] WLEN_RESET = wssd_pkg::WLEN_RESET;
  localparam logic [THR_W-1:0] THR_RESET = wssd_pkg::THR_RESET;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BEATS = 118;
  localparam int unsigned PHASE_PAUSE = 4;
  localparam int unsigned END_PAUSE = 80;

  typedef struct packed {
    logic steady;
    logic full;
  } verdict_t;

  // dut signals
  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [SW-1:0]     sample_i = '0;
  logic              restart_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              in_steady_state_o;
  logic              window_full_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // predictor state and register copies
  logic [SW-1:0]     hist_mem [MAX_W];
  int unsigned       wr_slot = 0;
  int unsigned       filled = 0;
  logic              steady_now = 1'b0;
  logic [WLEN_W-1:0] cfg_len = WLEN_RESET;
  logic [THR_W-1:0]  cfg_thr = THR_RESET;

  // expected verdicts and run bookkeeping
  verdict_t    pending_verdicts[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  window_steady_state_detector u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .restart_i         (restart_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .in_steady_state_o (in_steady_state_o),
    .window_full_o     (window_full_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // window length as the block applies it
  function automatic int unsigned active_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > MAX_W) return MAX_W;
    return cfg_len;
  endfunction

  function automatic void clear_window();
    wr_slot = 0;
    filled = 0;
    steady_now = 1'b0;
  endfunction

  // store one beat and work out the verdict it produces
  function automatic verdict_t predict_verdict(input logic [SW-1:0] smp, input logic rs);
    int unsigned n;
    verdict_t v;
    longint unsigned total, lo, hi, nmax, dev, spread, lim;
    n = active_len();
    v = '0;
    if (rs) begin
      clear_window();
      return v;
    end
    if (wr_slot >= n) wr_slot = 0;
    hist_mem[wr_slot] = smp;
    wr_slot++;
    if (wr_slot >= n) wr_slot = 0;
    if (filled < n) filled++;
    if (filled < n) begin
      steady_now = 1'b0;
      return v;
    end
    // sum, min and max over the window
    total = 0;
    hi = 0;
    lo = hist_mem[0];
    for (int i = 0; i < n; i++) begin
      total += hist_mem[i];
      if (hist_mem[i] < lo) lo = hist_mem[i];
      if (hist_mem[i] > hi) hi = hist_mem[i];
    end
    if (total == 0) begin
      steady_now = 1'b1;
    end else begin
      // deviation from mean and peak-to-peak, both scaled by n against the limit
      nmax = hi * n;
      dev = (nmax >= total) ? nmax - total : total - nmax;
      spread = (hi - lo) * n;
      lim = total * cfg_thr;
      steady_now = !(((dev << 16) >= lim) || ((spread << 16) >= lim));
    end
    v.steady = steady_now;
    v.full = 1'b1;
    return v;
  endfunction

  // one apb transfer, with the bus returned to idle afterwards
  task automatic apb_xfer(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (wr) begin
      if (idx == wssd_pkg::REG_WINDOW_LEN) begin
        cfg_len = wdata[WLEN_W-1:0];
        clear_window();
      end else begin
        cfg_thr = wdata[THR_W-1:0];
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic idx);
    logic [APB_DW-1:0] got, want;
    want = '0;
    apb_xfer(1'b0, idx, '0, got);
    if (idx == wssd_pkg::REG_WINDOW_LEN) begin
      want[WLEN_W-1:0] = cfg_len;
    end else begin
      want[THR_W-1:0] = cfg_thr;
    end
    if (got !== want) begin
      note_failure($sformatf("register %0d read: expected %0h got %0h", idx, want, got));
    end
  endtask

  task automatic apply_setting(input int unsigned len, input int unsigned thr);
    logic [APB_DW-1:0] unused;
    apb_xfer(1'b1, wssd_pkg::REG_WINDOW_LEN, len, unused);
    apb_xfer(1'b1, wssd_pkg::REG_OSC_THR, thr, unused);
    check_reg(wssd_pkg::REG_WINDOW_LEN);
    check_reg(wssd_pkg::REG_OSC_THR);
  endtask

  // offer one beat, with a random gap first, and record its verdict once taken
  task automatic send_beat(input logic [SW-1:0] smp, input logic rs);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= smp;
    restart_i <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_verdicts.push_back(predict_verdict(smp, rs));
  endtask

  // wait until every verdict is back, then let the block settle
  task automatic drain_results(input int unsigned pause);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (pause) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  // result beats: check against the oldest expectation, drive the stall
  always @(posedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          note_failure($sformatf("result beat %0d with nothing expected: steady %0b full %0b",
                                 results_seen, in_steady_state_o, window_full_o));
        end else begin
          want = pending_verdicts.pop_front();
          if (in_steady_state_o !== want.steady) begin
            note_failure($sformatf("result beat %0d: in_steady_state expected %0b got %0b",
                                   results_seen, want.steady, in_steady_state_o));
          end
          if (window_full_o !== want.full) begin
            note_failure($sformatf("result beat %0d: window_full expected %0b got %0b",
                                   results_seen, want.full, window_full_o));
          end
        end
      end
      // long hold-off takes priority over random stalls
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat and no bus transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("window_steady_state_detector regression: fail");
    $finish;
  end

  task automatic test_register_reset();
    check_reg(wssd_pkg::REG_WINDOW_LEN);
    check_reg(wssd_pkg::REG_OSC_THR);
  endtask

  // extremes, restarts, zero window, zero and full threshold, length 0
  task automatic test_directed_edges();
    apply_setting(2, THR_RESET);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'hFFFF, 1'b1);
    send_beat(16'hAAAA, 1'b0);
    send_beat(16'h5555, 1'b0);
    send_beat(16'h0000, 1'b1);
    drain_results(PHASE_PAUSE);
    // zero threshold
    apply_setting(2, 0);
    send_beat(16'd100, 1'b0);
    send_beat(16'd100, 1'b0);
    send_beat(16'd0, 1'b0);
    send_beat(16'd0, 1'b0);
    drain_results(PHASE_PAUSE);
    // length 0 behaves as 1, widest threshold
    apply_setting(0, 16'hFFFF);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'd1, 1'b0);
    send_beat(16'd0, 1'b1);
    send_beat(16'd0, 1'b0);
    drain_results(PHASE_PAUSE);
    // restart after the window has filled, then refill
    apply_setting(3, 16'hFFFF);
    send_beat(16'd1000, 1'b0);
    send_beat(16'd1010, 1'b0);
    send_beat(16'd1020, 1'b0);
    send_beat(16'd5, 1'b0);
    send_beat(16'd5, 1'b1);
    send_beat(16'd7, 1'b0);
    send_beat(16'd7, 1'b0);
    send_beat(16'd7, 1'b0);
    drain_results(PHASE_PAUSE);
  endtask

  // mostly near-constant runs around the threshold, with noise, zeros and restarts
  task automatic test_random_traffic();
    int unsigned len_tab[12] = '{16, 1, 64, 5, 127, 0, 33, 2, 8, 64, 3, 20};
    int unsigned thr_tab[12] = '{3277, 0, 3277, 65535, 0, 12000, 0, 0, 3277, 65535, 0, 0};
    int unsigned sent, pick, base, amp, run_len, smp;
    longint unsigned scaled;
    thr_tab[1] = $urandom_range(65535, 0);
    thr_tab[6] = $urandom_range(65535, 0);
    thr_tab[10] = $urandom_range(65535, 0);
    thr_tab[11] = $urandom_range(8000, 0);
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) set_idling(78, 8);
      if (ph == 8) set_idling(0, 0);
      apply_setting(len_tab[ph], thr_tab[ph]);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
          // level with jitter scaled to the threshold
          base = $urandom_range(65535, 0) >> $urandom_range(12, 0);
          scaled = base;
          scaled = (scaled * cfg_thr) >> 16;
          scaled = (scaled * $urandom_range(8, 0)) >> 2;
          amp = (scaled > 65535) ? 65535 : int'(scaled);
          run_len = active_len() + $urandom_range(2 * active_len(), 0);
          for (int k = 0; k < run_len && sent < PHASE_BEATS; k++) begin
            smp = base + $urandom_range(amp, 0);
            if (smp > 65535) smp = 65535;
            send_beat(SW'(smp), 1'b0);
            sent++;
          end
        end else if (pick < 80) begin
          // mostly zero window
          run_len = active_len() + $urandom_range(active_len(), 0);
          for (int k = 0; k < run_len && sent < PHASE_BEATS; k++) begin
            smp = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 1) : 0;
            send_beat(SW'(smp), 1'b0);
            sent++;
          end
        end else if (pick < 92) begin
          // full-range noise
          run_len = $urandom_range(active_len(), 1);
          for (int k = 0; k < run_len && sent < PHASE_BEATS; k++) begin
            send_beat(SW'($urandom_range(65535, 0)), 1'b0);
            sent++;
          end
        end else begin
          send_beat(SW'($urandom_range(65535, 0)), 1'b1);
          sent++;
        end
      end
      drain_results(PHASE_PAUSE);
    end
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    int unsigned lvl;
    set_idling(0, 0);
    apply_setting(4, THR_RESET);
    lvl = $urandom_range(60000, 1000);
    hold_left <= HOLD_CYCLES;
    repeat (24) send_beat(SW'(lvl + $urandom_range(40, 0)), 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(8, 78);
    test_register_reset();
    test_directed_edges();
    test_random_traffic();
    test_output_backpressure();
    drain_results(END_PAUSE);
    if (pending_verdicts.size() != 0) begin
      note_failure($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    end
    if (fail_count == 0) begin
      $display("window_steady_state_detector regression: pass");
    end else begin
      $display("window_steady_state_detector regression: fail");
    end
    $finish;
  end

endmodule
